@@ src/sapd_pkg.sv @@
package sapd_pkg;

   localparam int MAX_LEN     = 1024;
   localparam int MAX_LEVELS  = 11;
   localparam int ADDR_W      = 10;
   localparam int LEN_W       = 11;
   localparam int LVL_W       = 4;
   localparam int CHAR_W      = 8;
   localparam int RANK_W      = 10;
   localparam int SEC_W       = 11;
   localparam int KEY_W       = RANK_W + SEC_W + ADDR_W;
   localparam int HKEY_W      = RANK_W + SEC_W;
   localparam int RANK_AW     = LVL_W + ADDR_W;
   localparam int RANK_DEPTH  = MAX_LEVELS * MAX_LEN;
   localparam int SRCH_W      = 12;

   localparam logic [LEN_W-1:0] PAST_END = LEN_W'(MAX_LEN);

   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_COMPARE = 2'd1;
   localparam logic [1:0] REQ_RANGE   = 2'd2;

   localparam logic [1:0] KIND_BUILD   = 2'd0;
   localparam logic [1:0] KIND_COMPARE = 2'd1;
   localparam logic [1:0] KIND_RANGE   = 2'd2;

   localparam logic [1:0] CMP_LESS    = 2'b11;
   localparam logic [1:0] CMP_EQUAL   = 2'b00;
   localparam logic [1:0] CMP_GREATER = 2'b01;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_OVER_REPLY,
      OP_LVL_INIT,
      OP_LVL_STEP,
      OP_KG_RD,
      OP_KG_WR,
      OP_SORT_BEGIN,
      OP_RUN_BEGIN,
      OP_MS_RD,
      OP_MS_WR,
      OP_PASS_END,
      OP_SCAN_BEGIN,
      OP_RS_RD,
      OP_RS_WR,
      OP_LEVEL_NEXT,
      OP_BUILD_REPLY,
      OP_ERR_REPLY,
      OP_CMP_BEGIN,
      OP_CW_SKIP,
      OP_CW_RD,
      OP_CW_EV,
      OP_CMP_REPLY,
      OP_RNG_RD,
      OP_RNG_INIT,
      OP_RNG_LOOP,
      OP_POS_RD,
      OP_RNG_WALK,
      OP_RNG_STEP,
      OP_RNG_REPLY
   } dp_op_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LOAD,
      ST_LOAD_NEXT,
      ST_OVER_REPLY,
      ST_LVL_INIT,
      ST_LVL_STEP,
      ST_KG_RD,
      ST_KG_WR,
      ST_SORT_BEGIN,
      ST_PASS_CHECK,
      ST_RUN_CHECK,
      ST_RUN_BEGIN,
      ST_MS_RD,
      ST_MS_WR,
      ST_PASS_END,
      ST_SCAN_BEGIN,
      ST_RS_RD,
      ST_RS_WR,
      ST_LEVEL_NEXT,
      ST_BUILD_REPLY,
      ST_ERR_REPLY,
      ST_CMP_BEGIN,
      ST_CW_CHECK,
      ST_CW_RD,
      ST_CW_EV,
      ST_CMP_REPLY,
      ST_RNG_RD,
      ST_RNG_INIT,
      ST_RNG_LOOP,
      ST_POS_RD,
      ST_RNG_WALK,
      ST_RNG_STEP
   } ctrl_state_type;

   typedef struct packed {
      logic      accept;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] req_code;
      logic       built;
      logic       last;
      logic       over;
      logic       lvl_more;
      logic       i_last;
      logic       sort_more;
      logic       run_more;
      logic       merge_last;
      logic       lvl_last;
      logic       cmp_bad;
      logic       rng_bad;
      logic       cw_end;
      logic       cw_bit;
      logic       cw_diff;
      logic       rng_cont;
      logic       rng_phase;
   } dp_status_type;

endpackage

@@ src/sapd_controller.sv @@
module sapd_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sapd_pkg::dp_status_type status,
   output sapd_pkg::dp_cmd_type    cmd
);

   sapd_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sapd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != sapd_pkg::ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.op     = sapd_pkg::OP_NONE;
      unique case (state_ff)
         sapd_pkg::ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = sapd_pkg::ST_DISPATCH;
            end
         end
         sapd_pkg::ST_DISPATCH: begin
            case (status.req_code)
               sapd_pkg::REQ_LOAD: state_in = sapd_pkg::ST_LOAD;
               sapd_pkg::REQ_COMPARE: begin
                  if (status.built && !status.cmp_bad) state_in = sapd_pkg::ST_CMP_BEGIN;
                  else state_in = sapd_pkg::ST_ERR_REPLY;
               end
               sapd_pkg::REQ_RANGE: begin
                  if (status.built && !status.rng_bad) state_in = sapd_pkg::ST_RNG_RD;
                  else state_in = sapd_pkg::ST_ERR_REPLY;
               end
               default: state_in = sapd_pkg::ST_IDLE;
            endcase
         end
         sapd_pkg::ST_LOAD: begin
            cmd.op   = sapd_pkg::OP_LOAD;
            state_in = sapd_pkg::ST_LOAD_NEXT;
         end
         sapd_pkg::ST_LOAD_NEXT: begin
            if (status.last) state_in = sapd_pkg::ST_LVL_INIT;
            else if (status.over) state_in = sapd_pkg::ST_OVER_REPLY;
            else state_in = sapd_pkg::ST_IDLE;
         end
         sapd_pkg::ST_OVER_REPLY: begin
            cmd.op   = sapd_pkg::OP_OVER_REPLY;
            state_in = sapd_pkg::ST_IDLE;
         end
         sapd_pkg::ST_LVL_INIT: begin
            cmd.op   = sapd_pkg::OP_LVL_INIT;
            state_in = sapd_pkg::ST_LVL_STEP;
         end
         sapd_pkg::ST_LVL_STEP: begin
            cmd.op = sapd_pkg::OP_LVL_STEP;
            if (!status.lvl_more) state_in = sapd_pkg::ST_KG_RD;
         end
         sapd_pkg::ST_KG_RD: begin
            cmd.op   = sapd_pkg::OP_KG_RD;
            state_in = sapd_pkg::ST_KG_WR;
         end
         sapd_pkg::ST_KG_WR: begin
            cmd.op = sapd_pkg::OP_KG_WR;
            if (status.i_last) state_in = sapd_pkg::ST_SORT_BEGIN;
            else state_in = sapd_pkg::ST_KG_RD;
         end
         sapd_pkg::ST_SORT_BEGIN: begin
            cmd.op   = sapd_pkg::OP_SORT_BEGIN;
            state_in = sapd_pkg::ST_PASS_CHECK;
         end
         sapd_pkg::ST_PASS_CHECK: begin
            if (status.sort_more) state_in = sapd_pkg::ST_RUN_CHECK;
            else state_in = sapd_pkg::ST_SCAN_BEGIN;
         end
         sapd_pkg::ST_RUN_CHECK: begin
            if (status.run_more) state_in = sapd_pkg::ST_RUN_BEGIN;
            else state_in = sapd_pkg::ST_PASS_END;
         end
         sapd_pkg::ST_RUN_BEGIN: begin
            cmd.op   = sapd_pkg::OP_RUN_BEGIN;
            state_in = sapd_pkg::ST_MS_RD;
         end
         sapd_pkg::ST_MS_RD: begin
            cmd.op   = sapd_pkg::OP_MS_RD;
            state_in = sapd_pkg::ST_MS_WR;
         end
         sapd_pkg::ST_MS_WR: begin
            cmd.op = sapd_pkg::OP_MS_WR;
            if (status.merge_last) state_in = sapd_pkg::ST_RUN_CHECK;
            else state_in = sapd_pkg::ST_MS_RD;
         end
         sapd_pkg::ST_PASS_END: begin
            cmd.op   = sapd_pkg::OP_PASS_END;
            state_in = sapd_pkg::ST_PASS_CHECK;
         end
         sapd_pkg::ST_SCAN_BEGIN: begin
            cmd.op   = sapd_pkg::OP_SCAN_BEGIN;
            state_in = sapd_pkg::ST_RS_RD;
         end
         sapd_pkg::ST_RS_RD: begin
            cmd.op   = sapd_pkg::OP_RS_RD;
            state_in = sapd_pkg::ST_RS_WR;
         end
         sapd_pkg::ST_RS_WR: begin
            cmd.op = sapd_pkg::OP_RS_WR;
            if (!status.i_last) state_in = sapd_pkg::ST_RS_RD;
            else if (status.lvl_last) state_in = sapd_pkg::ST_BUILD_REPLY;
            else state_in = sapd_pkg::ST_LEVEL_NEXT;
         end
         sapd_pkg::ST_LEVEL_NEXT: begin
            cmd.op   = sapd_pkg::OP_LEVEL_NEXT;
            state_in = sapd_pkg::ST_KG_RD;
         end
         sapd_pkg::ST_BUILD_REPLY: begin
            cmd.op   = sapd_pkg::OP_BUILD_REPLY;
            state_in = sapd_pkg::ST_IDLE;
         end
         sapd_pkg::ST_ERR_REPLY: begin
            cmd.op   = sapd_pkg::OP_ERR_REPLY;
            state_in = sapd_pkg::ST_IDLE;
         end
         sapd_pkg::ST_CMP_BEGIN: begin
            cmd.op   = sapd_pkg::OP_CMP_BEGIN;
            state_in = sapd_pkg::ST_CW_CHECK;
         end
         sapd_pkg::ST_CW_CHECK: begin
            if (status.cw_end) begin
               if (status.req_code == sapd_pkg::REQ_COMPARE) state_in = sapd_pkg::ST_CMP_REPLY;
               else state_in = sapd_pkg::ST_RNG_LOOP;
               if (status.req_code != sapd_pkg::REQ_COMPARE) cmd.op = sapd_pkg::OP_RNG_STEP;
            end else if (status.cw_bit) begin
               state_in = sapd_pkg::ST_CW_RD;
            end else begin
               cmd.op = sapd_pkg::OP_CW_SKIP;
            end
         end
         sapd_pkg::ST_CW_RD: begin
            cmd.op   = sapd_pkg::OP_CW_RD;
            state_in = sapd_pkg::ST_CW_EV;
         end
         sapd_pkg::ST_CW_EV: begin
            cmd.op = sapd_pkg::OP_CW_EV;
            if (!status.cw_diff) state_in = sapd_pkg::ST_CW_CHECK;
            else if (status.req_code == sapd_pkg::REQ_COMPARE) state_in = sapd_pkg::ST_CMP_REPLY;
            else state_in = sapd_pkg::ST_RNG_STEP;
         end
         sapd_pkg::ST_CMP_REPLY: begin
            cmd.op   = sapd_pkg::OP_CMP_REPLY;
            state_in = sapd_pkg::ST_IDLE;
         end
         sapd_pkg::ST_RNG_RD: begin
            cmd.op   = sapd_pkg::OP_RNG_RD;
            state_in = sapd_pkg::ST_RNG_INIT;
         end
         sapd_pkg::ST_RNG_INIT: begin
            cmd.op   = sapd_pkg::OP_RNG_INIT;
            state_in = sapd_pkg::ST_RNG_LOOP;
         end
         sapd_pkg::ST_RNG_STEP: begin
            // walk found a mismatch
            cmd.op   = sapd_pkg::OP_RNG_STEP;
            state_in = sapd_pkg::ST_RNG_LOOP;
         end
         sapd_pkg::ST_RNG_LOOP: begin
            cmd.op = sapd_pkg::OP_RNG_LOOP;
            if (status.rng_cont) state_in = sapd_pkg::ST_POS_RD;
            else if (status.rng_phase) begin
               cmd.op   = sapd_pkg::OP_RNG_REPLY;
               state_in = sapd_pkg::ST_IDLE;
            end
         end
         sapd_pkg::ST_POS_RD: begin
            cmd.op   = sapd_pkg::OP_POS_RD;
            state_in = sapd_pkg::ST_RNG_WALK;
         end
         sapd_pkg::ST_RNG_WALK: begin
            cmd.op   = sapd_pkg::OP_RNG_WALK;
            state_in = sapd_pkg::ST_CW_CHECK;
         end
         default: state_in = sapd_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ src/sapd_datapath.sv @@
module sapd_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_type,
   input  logic [7:0]             req_char_value,
   input  logic                   req_last_char,
   input  logic [9:0]             req_pos_a,
   input  logic [10:0]            req_len_a,
   input  logic [9:0]             req_pos_b,
   input  logic [10:0]            req_len_b,
   input  sapd_pkg::dp_cmd_type    cmd,
   output sapd_pkg::dp_status_type status,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_reply_kind,
   output logic signed [1:0]      rsp_cmp_result,
   output logic [9:0]             rsp_range_left,
   output logic [9:0]             rsp_range_right,
   output logic [10:0]            rsp_text_length,
   output logic                   rsp_query_error
);

   localparam int AW  = sapd_pkg::ADDR_W;
   localparam int LW  = sapd_pkg::LEN_W;
   localparam int VW  = sapd_pkg::LVL_W;
   localparam int RW  = sapd_pkg::RANK_W;
   localparam int KW  = sapd_pkg::KEY_W;
   localparam int HW  = sapd_pkg::HKEY_W;
   localparam int SW  = sapd_pkg::SRCH_W;
   localparam int CW  = sapd_pkg::CHAR_W;

   // memories
   logic [CW-1:0] text_mem [sapd_pkg::MAX_LEN];
   logic [RW-1:0] rank_mem [sapd_pkg::RANK_DEPTH];
   logic [RW-1:0] pos_mem  [sapd_pkg::MAX_LEN];
   logic [KW-1:0] key0_mem [sapd_pkg::MAX_LEN];
   logic [KW-1:0] key1_mem [sapd_pkg::MAX_LEN];

   logic [CW-1:0] text_rd_ff;
   logic [RW-1:0] rank_rd0_ff, rank_rd1_ff, pos_rd_ff;
   logic [KW-1:0] key0_rd0_ff, key0_rd1_ff, key1_rd0_ff, key1_rd1_ff;

   // control registers
   logic [LW-1:0] n_ff, n_in;
   logic          built_ff, built_in;
   logic [VW-1:0] lvls_ff, lvls_in;
   logic          valid_ff, valid_in;

   // payload registers
   logic [1:0]    type_ff, type_in;
   logic [CW-1:0] ch_ff, ch_in;
   logic          last_ff, last_in;
   logic [AW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [LW-1:0] la_ff, la_in, lb_ff, lb_in;
   logic          over_ff, over_in;
   logic [VW-1:0] d_ff, d_in, l_ff, l_in, cbit_ff, cbit_in;
   logic [LW-1:0] i_ff, i_in, w_ff, w_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [LW-1:0] a_ff, a_in, b_ff, b_in, k_ff, k_in;
   logic [SW-1:0] lo_ff, lo_in;
   logic          sel_ff, sel_in;
   logic [RW-1:0] r_ff, r_in;
   logic [HW-1:0] prev_ff, prev_in;
   logic [LW-1:0] ci_ff, ci_in, cj_ff, cj_in, cl_ff, cl_in;
   logic [1:0]    wres_ff, wres_in;
   logic signed [SW-1:0] slo_ff, slo_in, shi_ff, shi_in;
   logic [RW-1:0] mi_ff, mi_in, left_ff, left_in, right_ff, right_in;
   logic          phase_ff, phase_in;
   logic [1:0]    kind_ff, kind_in, cmp_ff, cmp_in;
   logic [RW-1:0] rl_ff, rl_in, rr_ff, rr_in;
   logic [LW-1:0] tlen_ff, tlen_in;
   logic          err_ff, err_in;

   // combinational helpers
   logic [VW-1:0]  lm1;
   logic [LW-1:0]  pstep, ip, cstep, va, vb, base, n_m1;
   logic [sapd_pkg::RANK_AW-1:0] rank_ra0, rank_ra1, rank_wa;
   logic [AW-1:0]  key_ra0, key_ra1;
   logic [KW-1:0]  ka, kb, kg_key, key_wd;
   logic [RW-1:0]  kg_first, rn, rank_wd;
   logic [sapd_pkg::SEC_W-1:0] kg_second;
   logic [SW-1:0]  n12, lo_w, lo_2w, sum_a, sum_b, msum;
   logic [LW-1:0]  cl_sh, min_len;
   logic           take_a, full, inc;
   logic           text_we, rank_we, pos_we, key0_we, key1_we;
   logic [AW-1:0]  key0_wa;
   logic signed [SW-1:0] mis;

   assign lm1      = (l_ff == '0) ? '0 : l_ff - VW'(1);
   assign pstep    = LW'(1) << lm1;
   assign ip       = i_ff + pstep;
   assign cstep    = LW'(1) << cbit_ff;
   assign n12      = {1'b0, n_ff};
   assign n_m1     = n_ff - LW'(1);
   assign base     = built_ff ? '0 : n_ff;
   assign full     = (base == LW'(sapd_pkg::MAX_LEN));
   assign ka       = sel_ff ? key1_rd0_ff : key0_rd0_ff;
   assign kb       = sel_ff ? key1_rd1_ff : key0_rd1_ff;
   assign take_a   = (a_ff < mid_ff) && ((b_ff >= hi_ff) || (ka <= kb));
   assign key_wd   = take_a ? ka : kb;
   assign lo_w     = lo_ff + {1'b0, w_ff};
   assign lo_2w    = lo_ff + {w_ff, 1'b0};
   assign sum_a    = SW'(pa_ff) + SW'(la_ff);
   assign sum_b    = SW'(pb_ff) + SW'(lb_ff);
   assign msum     = slo_ff + shi_ff;
   assign mis      = $signed({2'b00, mi_ff});
   assign cl_sh    = cl_ff >> cbit_ff;
   assign min_len  = (la_ff < lb_ff) ? la_ff : lb_ff;
   assign va       = (ci_ff >= n_ff) ? sapd_pkg::PAST_END : {1'b0, rank_rd0_ff};
   assign vb       = (cj_ff >= n_ff) ? sapd_pkg::PAST_END : {1'b0, rank_rd1_ff};
   assign inc      = (i_ff != '0) && (ka[KW-1:AW] != prev_ff);
   assign rn       = r_ff + RW'(inc);

   assign kg_first  = (l_ff == '0) ? RW'(text_rd_ff) : rank_rd0_ff;
   assign kg_second = ((l_ff == '0) || (ip >= n_ff)) ? sapd_pkg::PAST_END
                                                   : {1'b0, rank_rd1_ff};
   assign kg_key    = {kg_first, kg_second, i_ff[AW-1:0]};

   always_comb begin
      if (cmd.op == sapd_pkg::OP_CW_RD) begin
         rank_ra0 = {cbit_ff, ci_ff[AW-1:0]};
         rank_ra1 = {cbit_ff, cj_ff[AW-1:0]};
      end else if (cmd.op == sapd_pkg::OP_RNG_RD) begin
         rank_ra0 = {lvls_ff - VW'(1), pa_ff};
         rank_ra1 = {lm1, ip[AW-1:0]};
      end else begin
         rank_ra0 = {lm1, i_ff[AW-1:0]};
         rank_ra1 = {lm1, ip[AW-1:0]};
      end
   end

   assign key_ra0 = (cmd.op == sapd_pkg::OP_RS_RD) ? i_ff[AW-1:0] : a_ff[AW-1:0];
   assign key_ra1 = b_ff[AW-1:0];

   assign text_we = (cmd.op == sapd_pkg::OP_LOAD) && !full;
   assign rank_we = (cmd.op == sapd_pkg::OP_RS_WR);
   assign rank_wa = {l_ff, ka[AW-1:0]};
   assign rank_wd = rn;
   assign pos_we  = rank_we && (l_ff == d_ff - VW'(1));
   assign key0_we = (cmd.op == sapd_pkg::OP_KG_WR) || ((cmd.op == sapd_pkg::OP_MS_WR) && sel_ff);
   assign key1_we = (cmd.op == sapd_pkg::OP_MS_WR) && !sel_ff;
   assign key0_wa = (cmd.op == sapd_pkg::OP_KG_WR) ? i_ff[AW-1:0] : k_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (text_we) text_mem[base[AW-1:0]] <= ch_ff;
      text_rd_ff <= text_mem[i_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rank_we) rank_mem[rank_wa] <= rank_wd;
      rank_rd0_ff <= rank_mem[rank_ra0];
      rank_rd1_ff <= rank_mem[rank_ra1];
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[rn] <= ka[AW-1:0];
      pos_rd_ff <= pos_mem[mi_ff];
   end

   always_ff @(posedge clock) begin
      if (key0_we) key0_mem[key0_wa] <= (cmd.op == sapd_pkg::OP_KG_WR) ? kg_key : key_wd;
      key0_rd0_ff <= key0_mem[key_ra0];
      key0_rd1_ff <= key0_mem[key_ra1];
   end

   always_ff @(posedge clock) begin
      if (key1_we) key1_mem[k_ff[AW-1:0]] <= key_wd;
      key1_rd0_ff <= key1_mem[key_ra0];
      key1_rd1_ff <= key1_mem[key_ra1];
   end

   always_comb begin
      n_in = n_ff; built_in = built_ff; lvls_in = lvls_ff; valid_in = 1'b0;
      type_in = type_ff; ch_in = ch_ff; last_in = last_ff;
      pa_in = pa_ff; pb_in = pb_ff; la_in = la_ff; lb_in = lb_ff;
      over_in = over_ff; d_in = d_ff; l_in = l_ff; cbit_in = cbit_ff;
      i_in = i_ff; w_in = w_ff; mid_in = mid_ff; hi_in = hi_ff;
      a_in = a_ff; b_in = b_ff; k_in = k_ff; lo_in = lo_ff; sel_in = sel_ff;
      r_in = r_ff; prev_in = prev_ff; ci_in = ci_ff; cj_in = cj_ff; cl_in = cl_ff;
      wres_in = wres_ff; slo_in = slo_ff; shi_in = shi_ff; mi_in = mi_ff;
      left_in = left_ff; right_in = right_ff; phase_in = phase_ff;
      kind_in = kind_ff; cmp_in = cmp_ff; rl_in = rl_ff; rr_in = rr_ff;
      tlen_in = tlen_ff; err_in = err_ff;

      if (cmd.accept) begin
         type_in = req_type; ch_in = req_char_value; last_in = req_last_char;
         pa_in = req_pos_a; la_in = req_len_a; pb_in = req_pos_b; lb_in = req_len_b;
      end

      case (cmd.op)
         sapd_pkg::OP_LOAD: begin
            built_in = 1'b0;
            lvls_in  = '0;
            over_in  = full;
            n_in     = full ? base : base + LW'(1);
         end
         sapd_pkg::OP_OVER_REPLY: begin
            valid_in = 1'b1; kind_in = sapd_pkg::KIND_BUILD; cmp_in = sapd_pkg::CMP_EQUAL;
            rl_in = '0; rr_in = '0; tlen_in = n_ff; err_in = 1'b1;
         end
         sapd_pkg::OP_LVL_INIT: begin
            d_in = VW'(1); l_in = '0; i_in = '0;
         end
         sapd_pkg::OP_LVL_STEP: begin
            if (status.lvl_more) d_in = d_ff + VW'(1);
         end
         sapd_pkg::OP_KG_WR: begin
            i_in = i_ff + LW'(1);
         end
         sapd_pkg::OP_SORT_BEGIN: begin
            w_in = LW'(1); sel_in = 1'b0; lo_in = '0;
         end
         sapd_pkg::OP_RUN_BEGIN: begin
            mid_in = (lo_w < n12) ? lo_w[LW-1:0] : n_ff;
            hi_in  = (lo_2w < n12) ? lo_2w[LW-1:0] : n_ff;
            a_in   = lo_ff[LW-1:0];
            b_in   = (lo_w < n12) ? lo_w[LW-1:0] : n_ff;
            k_in   = lo_ff[LW-1:0];
         end
         sapd_pkg::OP_MS_WR: begin
            if (take_a) a_in = a_ff + LW'(1);
            else b_in = b_ff + LW'(1);
            k_in = k_ff + LW'(1);
            if (status.merge_last) lo_in = lo_2w;
         end
         sapd_pkg::OP_PASS_END: begin
            sel_in = !sel_ff; w_in = w_ff << 1; lo_in = '0;
         end
         sapd_pkg::OP_SCAN_BEGIN: begin
            i_in = '0; r_in = '0;
         end
         sapd_pkg::OP_RS_WR: begin
            r_in = rn; prev_in = ka[KW-1:AW]; i_in = i_ff + LW'(1);
         end
         sapd_pkg::OP_LEVEL_NEXT: begin
            l_in = l_ff + VW'(1); i_in = '0;
         end
         sapd_pkg::OP_BUILD_REPLY: begin
            lvls_in = d_ff; built_in = 1'b1;
            valid_in = 1'b1; kind_in = sapd_pkg::KIND_BUILD; cmp_in = sapd_pkg::CMP_EQUAL;
            rl_in = '0; rr_in = '0; tlen_in = n_ff; err_in = over_ff;
         end
         sapd_pkg::OP_ERR_REPLY: begin
            valid_in = 1'b1; kind_in = type_ff; cmp_in = sapd_pkg::CMP_EQUAL;
            rl_in = '0; rr_in = '0; tlen_in = '0; err_in = 1'b1;
         end
         sapd_pkg::OP_CMP_BEGIN: begin
            ci_in = {1'b0, pa_ff}; cj_in = {1'b0, pb_ff}; cl_in = min_len;
            cbit_in = '0; wres_in = sapd_pkg::CMP_EQUAL;
         end
         sapd_pkg::OP_CW_SKIP: begin
            cbit_in = cbit_ff + VW'(1);
         end
         sapd_pkg::OP_CW_EV: begin
            if (va != vb) begin
               wres_in = (va < vb) ? sapd_pkg::CMP_LESS : sapd_pkg::CMP_GREATER;
            end else begin
               ci_in = ci_ff + cstep; cj_in = cj_ff + cstep; cbit_in = cbit_ff + VW'(1);
            end
         end
         sapd_pkg::OP_CMP_REPLY: begin
            valid_in = 1'b1; kind_in = sapd_pkg::KIND_COMPARE;
            rl_in = '0; rr_in = '0; tlen_in = '0; err_in = 1'b0;
            if (wres_ff != sapd_pkg::CMP_EQUAL) cmp_in = wres_ff;
            else if (la_ff != lb_ff)
               cmp_in = (la_ff < lb_ff) ? sapd_pkg::CMP_LESS : sapd_pkg::CMP_GREATER;
            else cmp_in = sapd_pkg::CMP_EQUAL;
         end
         sapd_pkg::OP_RNG_INIT: begin
            left_in = rank_rd0_ff; right_in = rank_rd0_ff;
            slo_in = '0; shi_in = $signed({2'b00, rank_rd0_ff}); phase_in = 1'b0;
         end
         sapd_pkg::OP_RNG_LOOP: begin
            if (status.rng_cont) begin
               mi_in = msum[RW:1];
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               slo_in   = $signed({2'b00, right_ff});
               shi_in   = $signed({1'b0, n_m1});
            end
         end
         sapd_pkg::OP_RNG_WALK: begin
            ci_in = {1'b0, pa_ff}; cj_in = {1'b0, pos_rd_ff}; cl_in = la_ff;
            cbit_in = '0; wres_in = sapd_pkg::CMP_EQUAL;
         end
         sapd_pkg::OP_RNG_STEP: begin
            if (!phase_ff) begin
               if (wres_ff == sapd_pkg::CMP_EQUAL) begin
                  left_in = mi_ff; shi_in = mis - SW'(1);
               end else slo_in = mis + SW'(1);
            end else begin
               if (wres_ff == sapd_pkg::CMP_EQUAL) begin
                  right_in = mi_ff; slo_in = mis + SW'(1);
               end else shi_in = mis - SW'(1);
            end
         end
         sapd_pkg::OP_RNG_REPLY: begin
            valid_in = 1'b1; kind_in = sapd_pkg::KIND_RANGE; cmp_in = sapd_pkg::CMP_EQUAL;
            rl_in = left_ff; rr_in = right_ff; tlen_in = '0; err_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= '0;
         built_ff <= 1'b0;
         lvls_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         n_ff     <= n_in;
         built_ff <= built_in;
         lvls_ff  <= lvls_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in; ch_ff <= ch_in; last_ff <= last_in;
      pa_ff <= pa_in; pb_ff <= pb_in; la_ff <= la_in; lb_ff <= lb_in;
      over_ff <= over_in; d_ff <= d_in; l_ff <= l_in; cbit_ff <= cbit_in;
      i_ff <= i_in; w_ff <= w_in; mid_ff <= mid_in; hi_ff <= hi_in;
      a_ff <= a_in; b_ff <= b_in; k_ff <= k_in; lo_ff <= lo_in; sel_ff <= sel_in;
      r_ff <= r_in; prev_ff <= prev_in; ci_ff <= ci_in; cj_ff <= cj_in; cl_ff <= cl_in;
      wres_ff <= wres_in; slo_ff <= slo_in; shi_ff <= shi_in; mi_ff <= mi_in;
      left_ff <= left_in; right_ff <= right_in; phase_ff <= phase_in;
      kind_ff <= kind_in; cmp_ff <= cmp_in; rl_ff <= rl_in; rr_ff <= rr_in;
      tlen_ff <= tlen_in; err_ff <= err_in;
   end

   assign status.req_code   = type_ff;
   assign status.built      = built_ff;
   assign status.last       = last_ff;
   assign status.over       = over_ff;
   assign status.lvl_more   = (d_ff < VW'(sapd_pkg::MAX_LEVELS)) &&
                              ((LW'(1) << (d_ff - VW'(1))) < n_ff);
   assign status.i_last     = (i_ff == n_m1);
   assign status.sort_more  = (w_ff < n_ff);
   assign status.run_more   = (lo_ff < n12);
   assign status.merge_last = ((k_ff + LW'(1)) == hi_ff);
   assign status.lvl_last   = (l_ff == d_ff - VW'(1));
   assign status.cmp_bad    = (sum_a > n12) || (sum_b > n12);
   assign status.rng_bad    = ({1'b0, pa_ff} >= n_ff) || (sum_a > n12);
   assign status.cw_end     = (cbit_ff == lvls_ff);
   assign status.cw_bit     = cl_sh[0];
   assign status.cw_diff    = (va != vb);
   assign status.rng_cont   = (slo_ff <= shi_ff);
   assign status.rng_phase  = phase_ff;

   assign rsp_valid       = valid_ff;
   assign rsp_reply_kind  = kind_ff;
   assign rsp_cmp_result  = $signed(cmp_ff);
   assign rsp_range_left  = rl_ff;
   assign rsp_range_right = rr_ff;
   assign rsp_text_length = tlen_ff;
   assign rsp_query_error = err_ff;

endmodule

@@ src/suffix_array_prefix_doubling_top.sv @@
// Load: a plain load or an overflowing load; a load with last_char runs the build.
// Compare: one rank read per set length bit.
// Range: two binary searches of about log2(n) steps, each step one substring compare.
// One transaction at a time; results are one-cycle strobes, never stalled.
// Synchronous reset clears control state; string and tables invalid until rebuilt.
module suffix_array_prefix_doubling_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_char_value,
   input  logic              req_last_char,
   input  logic [9:0]        req_pos_a,
   input  logic [10:0]       req_len_a,
   input  logic [9:0]        req_pos_b,
   input  logic [10:0]       req_len_b,
   output logic              rsp_valid,
   output logic [1:0]        rsp_reply_kind,
   output logic signed [1:0] rsp_cmp_result,
   output logic [9:0]        rsp_range_left,
   output logic [9:0]        rsp_range_right,
   output logic [10:0]       rsp_text_length,
   output logic              rsp_query_error
);

   sapd_pkg::dp_cmd_type    cmd;
   sapd_pkg::dp_status_type status;

   sapd_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   sapd_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_char_value  (req_char_value),
      .req_last_char   (req_last_char),
      .req_pos_a       (req_pos_a),
      .req_len_a       (req_len_a),
      .req_pos_b       (req_pos_b),
      .req_len_b       (req_len_b),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_reply_kind  (rsp_reply_kind),
      .rsp_cmp_result  (rsp_cmp_result),
      .rsp_range_left  (rsp_range_left),
      .rsp_range_right (rsp_range_right),
      .rsp_text_length (rsp_text_length),
      .rsp_query_error (rsp_query_error)
   );

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted transaction did not raise busy");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_query_error) |->
         (rsp_cmp_result == 2'sd0 && rsp_range_left == 10'd0 && rsp_range_right == 10'd0))
      else $error("error reply carries data");

endmodule

@@ dv/sapd_checker.sv @@
`timescale 1ns / 1ps

module sapd_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_char_value,
   input  logic              req_last_char,
   input  logic [9:0]        req_pos_a,
   input  logic [10:0]       req_len_a,
   input  logic [9:0]        req_pos_b,
   input  logic [10:0]       req_len_b,
   input  logic              rsp_valid,
   input  logic [1:0]        rsp_reply_kind,
   input  logic signed [1:0] rsp_cmp_result,
   input  logic [9:0]        rsp_range_left,
   input  logic [9:0]        rsp_range_right,
   input  logic [10:0]       rsp_text_length,
   input  logic              rsp_query_error,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  cmp;
      logic [9:0]  left;
      logic [9:0]  right;
      logic [10:0] tlen;
      logic        err;
   } reply_type;

   reply_type        replies_due[$];
   logic [7:0]       text_mem[sapd_pkg::MAX_LEN];
   int unsigned      lvl_rank[sapd_pkg::MAX_LEVELS][sapd_pkg::MAX_LEN];
   int unsigned      pos_of_rank[sapd_pkg::MAX_LEN];
   int unsigned      text_len;
   int unsigned      lvl_total;
   bit               built;

   assign pending = replies_due.size();

   function automatic int unsigned rank_of(int unsigned lvl, int unsigned pos);
      if (lvl >= sapd_pkg::MAX_LEVELS || pos >= text_len || pos >= sapd_pkg::MAX_LEN)
         return sapd_pkg::MAX_LEN;
      return lvl_rank[lvl][pos];
   endfunction

   function automatic void build_tables();
      bit [63:0]   keys[$];
      int unsigned n, d, r;
      bit [63:0]   first, second;
      n = text_len;
      d = 1;
      while (d < sapd_pkg::MAX_LEVELS && (1 << (d - 1)) < n) d++;
      for (int l = 0; l < d; l++) begin
         keys.delete();
         for (int i = 0; i < n; i++) begin
            if (l == 0) begin
               first = text_mem[i];
               second = sapd_pkg::MAX_LEN;
            end else begin
               first = lvl_rank[l-1][i];
               second = (i + (1 << (l - 1)) < n) ? lvl_rank[l-1][i + (1 << (l - 1))]
                                                 : sapd_pkg::MAX_LEN;
            end
            keys.push_back((((first << 17) | second) << 16) | i);
         end
         keys.sort();
         r = 0;
         for (int i = 0; i < n; i++) begin
            if (i > 0 && (keys[i] >> 16) != (keys[i-1] >> 16)) r++;
            lvl_rank[l][keys[i][15:0] % sapd_pkg::MAX_LEN] = r;
         end
      end
      for (int i = 0; i < n; i++) pos_of_rank[lvl_rank[d-1][i] % sapd_pkg::MAX_LEN] = i;
      lvl_total = d;
      built = 1;
   endfunction

   function automatic int order_substrings(int unsigned i, int unsigned l1,
                                           int unsigned j, int unsigned l2);
      int unsigned cl, a, b;
      cl = (l1 < l2) ? l1 : l2;
      for (int unsigned l = 0; l < lvl_total && l < 32; l++) begin
         if ((cl >> l) & 1) begin
            a = rank_of(l, i);
            b = rank_of(l, j);
            if (a != b) return (a < b) ? -1 : 1;
            i += 1 << l;
            j += 1 << l;
         end
      end
      if (l1 != l2) return (l1 < l2) ? -1 : 1;
      return 0;
   endfunction

   function automatic logic [1:0] cmp_code(int c);
      if (c < 0) return sapd_pkg::CMP_LESS;
      if (c > 0) return sapd_pkg::CMP_GREATER;
      return sapd_pkg::CMP_EQUAL;
   endfunction

   function automatic void predict_reply(logic [1:0] kind_in, logic [7:0] ch, logic last,
                                         int unsigned pa, int unsigned la,
                                         int unsigned pb, int unsigned lb);
      reply_type   rep;
      bit          over;
      int unsigned n;
      int          left, right, lo, hi, mi;
      rep = '0;
      n = text_len;
      over = 0;
      case (kind_in)
         sapd_pkg::REQ_LOAD: begin
            if (built) begin
               built = 0;
               lvl_total = 0;
               text_len = 0;
            end
            if (text_len < sapd_pkg::MAX_LEN) begin
               text_mem[text_len] = ch;
               text_len++;
            end else over = 1;
            if (last) build_tables();
            if (last || over) begin
               rep.kind = sapd_pkg::KIND_BUILD;
               rep.tlen = 11'(text_len);
               rep.err = over;
               replies_due.push_back(rep);
            end
         end
         sapd_pkg::REQ_COMPARE: begin
            rep.kind = sapd_pkg::KIND_COMPARE;
            if (!built || pa + la > n || pb + lb > n) rep.err = 1;
            else rep.cmp = cmp_code(order_substrings(pa, la, pb, lb));
            replies_due.push_back(rep);
         end
         sapd_pkg::REQ_RANGE: begin
            rep.kind = sapd_pkg::KIND_RANGE;
            if (!built || pa >= n || pa + la > n) rep.err = 1;
            else begin
               left = rank_of(lvl_total - 1, pa);
               right = left;
               lo = 0;
               hi = left;
               while (lo <= hi) begin
                  mi = (lo + hi) / 2;
                  if (order_substrings(pa, la, pos_of_rank[mi % sapd_pkg::MAX_LEN], la) == 0)
                  begin
                     left = mi;
                     hi = mi - 1;
                  end else lo = mi + 1;
               end
               lo = right;
               hi = n - 1;
               while (lo <= hi) begin
                  mi = (lo + hi) / 2;
                  if (order_substrings(pa, la, pos_of_rank[mi % sapd_pkg::MAX_LEN], la) == 0)
                  begin
                     right = mi;
                     lo = mi + 1;
                  end else hi = mi - 1;
               end
               rep.left = 10'(left);
               rep.right = 10'(right);
            end
            replies_due.push_back(rep);
         end
         default: ;
      endcase
   endfunction

   initial begin
      fail_count = 0;
      text_len = 0;
      lvl_total = 0;
      built = 0;
   end

   always @(posedge clock) begin
      reply_type got, want;
      if (!reset) begin
         if (rsp_valid) begin
            got = '{rsp_reply_kind, rsp_cmp_result, rsp_range_left, rsp_range_right,
                    rsp_text_length, rsp_query_error};
            if (replies_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected reply: kind %0d cmp %0d left %0d right %0d len %0d err %0d",
                           got.kind, $signed(got.cmp), got.left, got.right, got.tlen,
                           got.err);
            end else begin
               want = replies_due.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: exp kind %0d cmp %0d left %0d right %0d len %0d err %0d",
                              want.kind, $signed(want.cmp), want.left, want.right,
                              want.tlen, want.err);
                     $display("          got kind %0d cmp %0d left %0d right %0d len %0d err %0d",
                              got.kind, $signed(got.cmp), got.left, got.right,
                              got.tlen, got.err);
                  end
               end
            end
         end
         if (start && !busy)
            predict_reply(req_type, req_char_value, req_last_char, req_pos_a, req_len_a,
                          req_pos_b, req_len_b);
      end
   end

endmodule

@@ dv/suffix_array_prefix_doubling_top_test.sv @@
`timescale 1ns / 1ps

module suffix_array_prefix_doubling_top_test;

   localparam int RUN_LIMIT = 5000000;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_type;
   logic [7:0]        req_char_value;
   logic              req_last_char;
   logic [9:0]        req_pos_a;
   logic [10:0]       req_len_a;
   logic [9:0]        req_pos_b;
   logic [10:0]       req_len_b;
   logic              rsp_valid;
   logic [1:0]        rsp_reply_kind;
   logic signed [1:0] rsp_cmp_result;
   logic [9:0]        rsp_range_left;
   logic [9:0]        rsp_range_right;
   logic [10:0]       rsp_text_length;
   logic              rsp_query_error;
   int                fail_count;
   int                pending;
   int                cycles;
   int                sent;
   int unsigned       text_n;
   bit                no_gaps;

   suffix_array_prefix_doubling_top i_dut (.*);

   sapd_checker i_checker (.*);

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send(logic [1:0] kind, int unsigned ch, int unsigned last,
                       int unsigned pa, int unsigned la, int unsigned pb, int unsigned lb);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_type <= kind;
      req_char_value <= 8'(ch);
      req_last_char <= 1'(last);
      req_pos_a <= 10'(pa);
      req_len_a <= 11'(la);
      req_pos_b <= 10'(pb);
      req_len_b <= 11'(lb);
      do @(posedge clock); while (busy);
      sent++;
   endtask

   task automatic load_char(int unsigned ch, int unsigned last);
      send(sapd_pkg::REQ_LOAD, ch, last, $urandom_range(0, 1023), $urandom_range(0, 2047),
           $urandom_range(0, 1023), $urandom_range(0, 2047));
   endtask

   task automatic load_text(int unsigned n, int unsigned alpha);
      for (int i = 0; i < n; i++)
         load_char(alpha == 0 ? $urandom_range(0, 255) : 97 + $urandom_range(0, alpha - 1),
                   i == n - 1);
      text_n = n;
   endtask

   task automatic random_query();
      int unsigned pa, la, pb, lb, pick;
      pick = $urandom_range(0, 99);
      pa = $urandom_range(0, text_n - 1);
      la = $urandom_range(0, text_n - pa);
      pb = $urandom_range(0, text_n - 1);
      lb = ($urandom_range(0, 2) == 0) ? la : $urandom_range(0, text_n - pb);
      if (pb + lb > text_n) lb = text_n - pb;
      if (pick < 8) begin
         pa = $urandom_range(0, 1023);
         la = $urandom_range(0, 2047);
      end
      if (pick < 2)
         send(REQ_UNKNOWN, $urandom_range(0, 255), $urandom_range(0, 1), pa, la, pb, lb);
      else if (pick < 50)
         send(sapd_pkg::REQ_COMPARE, $urandom_range(0, 255), $urandom_range(0, 1),
              pa, la, pb, lb);
      else
         send(sapd_pkg::REQ_RANGE, $urandom_range(0, 255), $urandom_range(0, 1),
              pa, la, pb, lb);
   endtask

   initial begin
      reset <= 1;
      start <= 0;
      req_type <= sapd_pkg::REQ_LOAD;
      req_char_value <= 0;
      req_last_char <= 0;
      req_pos_a <= 0;
      req_len_a <= 0;
      req_pos_b <= 0;
      req_len_b <= 0;
      sent = 0;
      text_n = 0;
      no_gaps = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      send(sapd_pkg::REQ_COMPARE, 0, 0, 0, 0, 0, 0);
      send(sapd_pkg::REQ_RANGE, 0, 0, 0, 0, 0, 0);
      send(REQ_UNKNOWN, 8'hff, 1, 1023, 2047, 1023, 2047);
      load_char(8'h00, 1);
      text_n = 1;
      send(sapd_pkg::REQ_COMPARE, 0, 0, 0, 1, 0, 1);
      send(sapd_pkg::REQ_RANGE, 0, 0, 0, 0, 0, 0);
      send(sapd_pkg::REQ_RANGE, 0, 0, 1, 0, 0, 0);
      load_char("a", 0);
      load_char("b", 0);
      send(sapd_pkg::REQ_COMPARE, 0, 0, 0, 1, 1, 1);
      load_char("a", 0);
      load_char("b", 1);
      send(sapd_pkg::REQ_COMPARE, 0, 0, 0, 2, 2, 2);
      send(sapd_pkg::REQ_COMPARE, 0, 0, 1, 3, 0, 2);
      send(sapd_pkg::REQ_COMPARE, 0, 0, 0, 3, 0, 4);
      send(sapd_pkg::REQ_COMPARE, 0, 0, 0, 3, 2, 3);
      send(sapd_pkg::REQ_RANGE, 0, 0, 0, 2, 0, 0);
      send(sapd_pkg::REQ_RANGE, 0, 0, 3, 1, 0, 0);
      send(sapd_pkg::REQ_RANGE, 0, 0, 2, 3, 0, 0);

      // full buffer, overflow drops, then build on the stored text
      no_gaps = 1;
      for (int i = 0; i < sapd_pkg::MAX_LEN; i++) load_char($urandom_range(0, 255), 0);
      no_gaps = 0;
      load_char(8'h5a, 0);
      load_char(8'ha5, 0);
      load_char(8'h3c, 1);
      text_n = sapd_pkg::MAX_LEN;
      send(sapd_pkg::REQ_COMPARE, 0, 0, 0, 1024, 0, 1024);
      send(sapd_pkg::REQ_COMPARE, 0, 0, 1023, 1, 0, 1023);
      send(sapd_pkg::REQ_COMPARE, 0, 0, 1, 1023, 1023, 1);
      send(sapd_pkg::REQ_RANGE, 0, 0, 0, 1024, 0, 0);
      send(sapd_pkg::REQ_RANGE, 0, 0, 1023, 1, 0, 0);
      send(sapd_pkg::REQ_RANGE, 0, 0, 512, 0, 0, 0);
      send(sapd_pkg::REQ_RANGE, 0, 0, 1000, 25, 0, 0);
      for (int i = 0; i < 20; i++) random_query();

      sent = 0;
      while (sent < 750) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            load_char($urandom_range(0, 255), 0);
            random_query();
         end
         load_text(($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16),
                   $urandom_range(0, 3));
         repeat ($urandom_range(4, 14)) random_query();
      end

      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
